/* rtl/sed_pkg.sv */
package sed_pkg;

  // Fixed field widths
  localparam int COORD_W = 16;
  localparam int DIST_W  = 32;

  // Configuration port geometry: 64-bit registers at 8-byte spacing
  localparam int APB_ADDR_W = 5;
  localparam int APB_DATA_W = 64;

  // Register indexes (paddr[4:3])
  localparam logic [1:0] REG_ROW0 = 2'd0;
  localparam logic [1:0] REG_ROW1 = 2'd1;
  localparam logic [1:0] REG_ROW2 = 2'd2;

  // One point correspondence
  typedef struct packed {
    logic signed [COORD_W-1:0] first_u;
    logic signed [COORD_W-1:0] first_v;
    logic signed [COORD_W-1:0] first_w;
    logic signed [COORD_W-1:0] second_u;
    logic signed [COORD_W-1:0] second_v;
    logic signed [COORD_W-1:0] second_w;
  } in_t;

  // One result
  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic              zero_denominator;
  } out_t;

  // Control travelling down the divider stages
  typedef struct packed {
    logic valid;
    logic zero;
    logic sat;
  } div_ctl_t;

endpackage

/* rtl/sed_div_step.sv */
module sed_div_step #(
  parameter int DEN_W = 74,
  parameter int SHIFT = 0
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  sed_pkg::div_ctl_t   ctl_in,
  input  logic [DEN_W-1:0]    den_in,
  input  logic [DEN_W+31:0]   rem_in,
  input  logic [31:0]         q_in,
  output sed_pkg::div_ctl_t   ctl_out,
  output logic [DEN_W-1:0]    den_out,
  output logic [DEN_W+31:0]   rem_out,
  output logic [31:0]         q_out
);
  import sed_pkg::*;

  localparam int          RW   = DEN_W + 32;
  localparam logic [31:0] QBIT = 32'd1 << SHIFT;

  logic [RW-1:0] trial;
  logic [RW:0]   diff;

  // Trial subtract of the shifted divisor
  assign trial = RW'(den_in) << SHIFT;
  assign diff  = {1'b0, rem_in} - {1'b0, trial};

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out <= '0;
    end else if (en) begin
      ctl_out <= ctl_in;
    end
  end

  // Restore on borrow, else keep the difference and set the quotient bit
  always_ff @(posedge clk) begin
    if (en) begin
      den_out <= den_in;
      if (!diff[RW]) begin
        rem_out <= diff[RW-1:0];
        q_out   <= q_in | QBIT;
      end else begin
        rem_out <= rem_in;
        q_out   <= q_in;
      end
    end
  end

endmodule

/* rtl/sampson_epipolar_distance.sv */
// Sampson epipolar distance of point correspondences under a fundamental matrix F held in
// three 64-bit registers (row r at byte address 8*r, columns packed COEF_WIDTH bits apiece,
// signed with 16 fraction bits). Each request carries two homogeneous points x and y; the
// result is floor((x.Fy)^2 * 2^RESULT_FRAC_BITS / (|Fy|01^2 + |F'x|01^2)), saturated to
// all ones, with zero_denominator set (and distance all ones) when the denominator is zero.
// The block accepts one request every cycle unless the output stalls: ten
// stages form the epipolar lines, the numerator square and the denominator (every multiply
// split to fit 32x32 or smaller), then a 32-stage restoring divider retires one quotient
// bit per stage, and an output register holds the result. A stalled output freezes the
// whole pipeline in place; nothing is dropped or repeated. F should be written while idle.
module sampson_epipolar_distance #(
  parameter int COEF_WIDTH       = 18,
  parameter int RESULT_FRAC_BITS = 8
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  sed_pkg::in_t                        in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output sed_pkg::out_t                       out_data,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [sed_pkg::APB_ADDR_W-1:0]      paddr,
  input  logic [sed_pkg::APB_DATA_W-1:0]      pwdata,
  output logic [sed_pkg::APB_DATA_W-1:0]      prdata,
  output logic                                pready
);
  import sed_pkg::*;

  localparam int KW   = COEF_WIDTH;
  localparam int CW   = COORD_W;
  localparam int F    = RESULT_FRAC_BITS;
  localparam int PW   = CW + KW;          // coefficient * coordinate
  localparam int LW   = PW + 2;           // epipolar line component
  localparam int H    = (LW + 1) / 2;     // low half of a line component
  localparam int HW   = LW - H;           // high half
  localparam int NHW  = CW + HW;
  localparam int NLW  = CW + H + 1;
  localparam int TW   = CW + LW;          // coordinate * line component
  localparam int NW   = TW + 2;           // numerator
  localparam int SQW  = 2 * LW + 1;
  localparam int DW   = 2 * LW + 2;       // denominator
  localparam int P    = (NW + 2) / 3;     // piece of |n| for squaring
  localparam int P2W  = NW - 2 * P;
  localparam int NSW  = 2 * NW + 2;
  localparam int AW   = 2 * NW + F;
  localparam int RW   = DW + 32;
  localparam int CMPW = ((AW > RW) ? AW : RW) + 1;

  // ---------------------------------------------------------------- config port
  logic [3*KW-1:0] fmat [3];

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < 3; r++) fmat[r] <= '0;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[4:3])
        REG_ROW0: fmat[0] <= pwdata[3*KW-1:0];
        REG_ROW1: fmat[1] <= pwdata[3*KW-1:0];
        REG_ROW2: fmat[2] <= pwdata[3*KW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:3])
      REG_ROW0: prdata = APB_DATA_W'(fmat[0]);
      REG_ROW1: prdata = APB_DATA_W'(fmat[1]);
      REG_ROW2: prdata = APB_DATA_W'(fmat[2]);
      default:  prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------- flow control
  logic advance;
  logic [8:0] vld;  // vld[k] is stage k+1

  assign advance  = !out_valid || out_ready;
  assign in_ready = advance;

  // ---------------------------------------------------------------- stage 1: products
  logic signed [KW-1:0] coef [3][3];
  logic signed [CW-1:0] px_in [3];
  logic signed [CW-1:0] py_in [3];

  always_comb begin
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 3; c++)
        coef[r][c] = $signed(fmat[r][c*KW +: KW]);
    px_in[0] = in_data.first_u;
    px_in[1] = in_data.first_v;
    px_in[2] = in_data.first_w;
    py_in[0] = in_data.second_u;
    py_in[1] = in_data.second_v;
    py_in[2] = in_data.second_w;
  end

  logic signed [PW-1:0] pry1 [3][3];
  logic signed [PW-1:0] prx1 [3][3];
  logic signed [CW-1:0] px1  [3];

  always_ff @(posedge clk) begin
    if (advance) begin
      for (int i = 0; i < 3; i++) begin
        px1[i] <= px_in[i];
        for (int j = 0; j < 3; j++) begin
          pry1[i][j] <= coef[i][j] * py_in[j];
          prx1[i][j] <= coef[j][i] * px_in[j];
        end
      end
    end
  end

  // ---------------------------------------------------------------- stage 2: lines
  logic signed [LW-1:0] ly2 [3];
  logic signed [LW-1:0] lx2 [3];
  logic signed [CW-1:0] px2 [3];

  always_ff @(posedge clk) begin
    if (advance) begin
      for (int i = 0; i < 3; i++) begin
        px2[i] <= px1[i];
        ly2[i] <= LW'(pry1[i][0]) + LW'(pry1[i][1]) + LW'(pry1[i][2]);
        lx2[i] <= LW'(prx1[i][0]) + LW'(prx1[i][1]) + LW'(prx1[i][2]);
      end
    end
  end

  // ---------------------------------------------------------------- stage 3: split multiplies
  logic signed [HW-1:0] yhi [3];
  logic signed [H:0]    ylo [3];
  logic signed [LW-1:0] lsrc [4];
  logic signed [HW-1:0] lhi [4];
  logic        [H-1:0]  llo [4];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      yhi[i] = $signed(ly2[i][LW-1:H]);
      ylo[i] = $signed({1'b0, ly2[i][H-1:0]});
    end
    lsrc[0] = lx2[0];
    lsrc[1] = lx2[1];
    lsrc[2] = ly2[0];
    lsrc[3] = ly2[1];
    for (int k = 0; k < 4; k++) begin
      lhi[k] = $signed(lsrc[k][LW-1:H]);
      llo[k] = lsrc[k][H-1:0];
    end
  end

  logic signed [NHW-1:0]  nh3  [3];
  logic signed [NLW-1:0]  nl3  [3];
  logic signed [2*HW-1:0] shh3 [4];
  logic signed [LW:0]     shl3 [4];
  logic        [2*H-1:0]  sll3 [4];

  always_ff @(posedge clk) begin
    if (advance) begin
      for (int i = 0; i < 3; i++) begin
        nh3[i] <= yhi[i] * px2[i];
        nl3[i] <= ylo[i] * px2[i];
      end
      for (int k = 0; k < 4; k++) begin
        shh3[k] <= lhi[k] * lhi[k];
        shl3[k] <= lhi[k] * $signed({1'b0, llo[k]});
        sll3[k] <= llo[k] * llo[k];
      end
    end
  end

  // ---------------------------------------------------------------- stage 4: recombine halves
  logic signed [SQW-1:0] sqsum [4];

  always_comb begin
    for (int k = 0; k < 4; k++)
      sqsum[k] = (SQW'(shh3[k]) <<< (2 * H)) + (SQW'(shl3[k]) <<< (H + 1))
               + $signed(SQW'(sll3[k]));
  end

  logic signed [TW-1:0]   t4  [3];
  logic        [2*LW-1:0] sq4 [4];

  always_ff @(posedge clk) begin
    if (advance) begin
      for (int i = 0; i < 3; i++) t4[i] <= (TW'(nh3[i]) <<< H) + TW'(nl3[i]);
      for (int k = 0; k < 4; k++) sq4[k] <= sqsum[k][2*LW-1:0];
    end
  end

  // ---------------------------------------------------------------- stage 5: numerator, denominator
  logic signed [NW-1:0] n5;
  logic        [DW-1:0] den5;

  always_ff @(posedge clk) begin
    if (advance) begin
      n5   <= NW'(t4[0]) + NW'(t4[1]) + NW'(t4[2]);
      den5 <= DW'(sq4[0]) + DW'(sq4[1]) + DW'(sq4[2]) + DW'(sq4[3]);
    end
  end

  // ---------------------------------------------------------------- stage 6: magnitude
  logic [NW-1:0] na6;
  logic [DW-1:0] den6;

  always_ff @(posedge clk) begin
    if (advance) begin
      na6  <= n5[NW-1] ? $unsigned(-n5) : $unsigned(n5);
      den6 <= den5;
    end
  end

  // ---------------------------------------------------------------- stage 7: square partials
  logic [P-1:0]   na_a0, na_a1;
  logic [P2W-1:0] na_a2;

  assign na_a0 = na6[P-1:0];
  assign na_a1 = na6[2*P-1:P];
  assign na_a2 = na6[NW-1:2*P];

  logic [2*P-1:0] m00, m11, m22, m01, m02, m12;
  logic [DW-1:0]  den7;

  always_ff @(posedge clk) begin
    if (advance) begin
      m00  <= na_a0 * na_a0;
      m11  <= na_a1 * na_a1;
      m22  <= na_a2 * na_a2;
      m01  <= na_a0 * na_a1;
      m02  <= na_a0 * na_a2;
      m12  <= na_a1 * na_a2;
      den7 <= den6;
    end
  end

  // ---------------------------------------------------------------- stage 8: partial sums
  logic [NSW-1:0] slo8, smid8, shi8;
  logic [DW-1:0]  den8;

  always_ff @(posedge clk) begin
    if (advance) begin
      slo8  <= NSW'(m00) + (NSW'(m01) << (P + 1));
      smid8 <= NSW'(m11) + (NSW'(m02) << 1);
      shi8  <= (NSW'(m12) << 1) + (NSW'(m22) << P);
      den8  <= den7;
    end
  end

  // ---------------------------------------------------------------- stage 9: numerator square
  logic [NSW-1:0]  nsq_sum;
  logic [2*NW-1:0] nsq9;
  logic [DW-1:0]   den9;

  assign nsq_sum = slo8 + (smid8 << (2 * P)) + (shi8 << (3 * P));

  always_ff @(posedge clk) begin
    if (advance) begin
      nsq9 <= nsq_sum[2*NW-1:0];
      den9 <= den8;
    end
  end

  // ---------------------------------------------------------------- stage 10: range check
  logic [CMPW-1:0] a_ext, dlim_ext;

  assign a_ext    = CMPW'(nsq9) << F;
  assign dlim_ext = CMPW'(den9) << 32;

  div_ctl_t      ctl10;
  logic [DW-1:0] den10;
  logic [RW-1:0] rem10;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld   <= '0;
      ctl10 <= '0;
    end else if (advance) begin
      vld         <= {vld[7:0], in_valid};
      ctl10.valid <= vld[8];
      ctl10.zero  <= (den9 == '0);
      ctl10.sat   <= (a_ext >= dlim_ext);
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      den10 <= den9;
      rem10 <= a_ext[RW-1:0];
    end
  end

  // ---------------------------------------------------------------- divider, MSB first
  div_ctl_t      ctl_c [33];
  logic [DW-1:0] den_c [33];
  logic [RW-1:0] rem_c [33];
  logic [31:0]   q_c   [33];

  assign ctl_c[0] = ctl10;
  assign den_c[0] = den10;
  assign rem_c[0] = rem10;
  assign q_c[0]   = '0;

  for (genvar s = 0; s < 32; s++) begin : g_div
    sed_div_step #(
      .DEN_W (DW),
      .SHIFT (31 - s)
    ) u_step (
      .clk     (clk),
      .rst     (rst),
      .en      (advance),
      .ctl_in  (ctl_c[s]),
      .den_in  (den_c[s]),
      .rem_in  (rem_c[s]),
      .q_in    (q_c[s]),
      .ctl_out (ctl_c[s+1]),
      .den_out (den_c[s+1]),
      .rem_out (rem_c[s+1]),
      .q_out   (q_c[s+1])
    );
  end

  // ---------------------------------------------------------------- output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= ctl_c[32].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data.distance         <= (ctl_c[32].zero || ctl_c[32].sat) ? '1 : q_c[32];
      out_data.zero_denominator <= ctl_c[32].zero;
    end
  end

`ifndef ASSERT_OFF
  // A stall must freeze the front of the pipe
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(vld) && $stable(ctl10))
    else $error("pipeline moved during a stall");

  // In-range quotients leave a remainder below the divisor
  a_rem_below_den: assert property (@(posedge clk) disable iff (rst)
    ctl_c[32].valid && !ctl_c[32].zero && !ctl_c[32].sat |-> rem_c[32] < RW'(den_c[32]))
    else $error("divider remainder out of range");

  // Zero denominator always reports full scale
  a_zero_full_scale: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.zero_denominator |-> out_data.distance == '1)
    else $error("zero denominator without saturated distance");
`endif

endmodule
